FILE: hw/rtl/vpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ============================================================================
package vpa_pkg;

    localparam int ADDR_BITS = 20;
    localparam int JOB_BITS  = 10;
    localparam int JCNT_BITS = 11;

    localparam logic [ADDR_BITS-1:0] DEFAULT_MEMORY    = 20'd100000;
    localparam logic [JCNT_BITS-1:0] DEFAULT_JOB_COUNT = 11'd1024;

    // Operation codes.
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Placement rules; any other code acts as first fit.
    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;
    localparam logic [1:0] FIT_FIRST = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [1:0] STATUS_BAD_JOB  = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [1:0] CFG_JOB_COUNT   = 2'd1;
    localparam logic [1:0] CFG_MEMORY_SIZE = 2'd2;

    typedef struct packed {
        logic                 func;
        logic [JOB_BITS-1:0]  job_id;
        logic [ADDR_BITS-1:0] request_size;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] start_address;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
        logic                 busy;
        logic [JOB_BITS-1:0]  owner;
    } entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/variable_partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// variable_partition_allocator
// Address-ordered partition table with best, worst and first fit placement.
// ============================================================================
// Usage: each input word carries an operation (allocate or release), a job
// id and a request size; every input word produces exactly one output word
// with a status and the start address of the partition involved.
// Both channels use valid/stall. The input is stalled while a word is being
// worked on; the result sits in an output register, so a new word is taken
// while an earlier result still waits for the receiver. A stalled output
// holds its word unchanged; the block then finishes the next word and waits.
// Structure: the table sits in one memory with a registered read, and all work
// goes through its single read and single write port. An allocation reads
// and weighs the entries in turn, then moves the entries behind the chosen
// one up by one for a split. A release scans until the owner's entry, reads
// its upper neighbor and closes the gap by moving later entries down.
// Reset clears the configuration to first defaults (best fit, 1024 jobs,
// 100000 bytes) and leaves one free partition; writing memory_size does the
// same to the table, with no clearing pass.
// ============================================================================
module variable_partition_allocator #(
    parameter int MAX_PARTITIONS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire vpa_pkg::in_word_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output vpa_pkg::out_word_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [vpa_pkg::ADDR_BITS-1:0] cfg_data
);
    import vpa_pkg::*;

    localparam int IW = $clog2(MAX_PARTITIONS);

    logic [1:0]           fit_mode_reg;
    logic [JCNT_BITS-1:0] job_count_reg;
    logic [ADDR_BITS-1:0] memory_size_reg;
    logic                 init;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    entry_t               rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    entry_t               wr_data;

    // A write of memory_size also resets the table to one free partition.
    assign init = cfg_we && (cfg_index == CFG_MEMORY_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= FIT_BEST;
            job_count_reg   <= DEFAULT_JOB_COUNT;
            memory_size_reg <= DEFAULT_MEMORY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[1:0];
                CFG_JOB_COUNT:   job_count_reg   <= cfg_data[JCNT_BITS-1:0];
                CFG_MEMORY_SIZE: memory_size_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    vpa_ctrl #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .fit_mode  (fit_mode_reg),
        .job_count (job_count_reg),
        .init      (init),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    vpa_table #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .init        (init),
        .memory_size (memory_size_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/vpa_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vpa_table
// Partition table memory with registered read. Entry zero reads as a single
// free partition of the whole memory until written after reset or init.
// ============================================================================
module vpa_table #(
    parameter int MAX_PARTITIONS = 64,
    localparam int IW = $clog2(MAX_PARTITIONS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          init,
    input  wire logic [vpa_pkg::ADDR_BITS-1:0] memory_size,
    input  wire logic                          rd_en,
    input  wire logic [IW-1:0]                 rd_addr,
    output vpa_pkg::entry_t                    rd_data,
    input  wire logic                          wr_en,
    input  wire logic [IW-1:0]                 wr_addr,
    input  wire vpa_pkg::entry_t               wr_data
);
    import vpa_pkg::*;

    entry_t mem [MAX_PARTITIONS];
    entry_t rd_q_reg;
    logic   ov_reg;
    logic   rd_ov_reg;
    entry_t init_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // The override stands for entry zero until the controller writes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg    <= 1'b1;
            rd_ov_reg <= 1'b0;
        end
        else
        begin
            if (init)
            begin
                ov_reg <= 1'b1;
            end
            else if (wr_en && wr_addr == '0)
            begin
                ov_reg <= 1'b0;
            end
            if (rd_en)
            begin
                rd_ov_reg <= ov_reg && (rd_addr == '0);
            end
        end
    end

    always_comb
    begin
        init_entry       = '0;
        init_entry.size  = memory_size;
        rd_data          = rd_ov_reg ? init_entry : rd_q_reg;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/vpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vpa_ctrl
// Sequencer that scans, splits and merges table entries, plus the result
// register of the output channel.
// ============================================================================
module vpa_ctrl #(
    parameter int MAX_PARTITIONS = 64,
    localparam int IW = $clog2(MAX_PARTITIONS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire vpa_pkg::in_word_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output vpa_pkg::out_word_t                 out_data,
    input  wire logic [1:0]                    fit_mode,
    input  wire logic [vpa_pkg::JCNT_BITS-1:0] job_count,
    input  wire logic                          init,
    output logic                               rd_en,
    output logic [IW-1:0]                      rd_addr,
    input  wire vpa_pkg::entry_t               rd_data,
    output logic                               wr_en,
    output logic [IW-1:0]                      wr_addr,
    output vpa_pkg::entry_t                    wr_data
);
    import vpa_pkg::*;

    localparam int CW = $clog2(MAX_PARTITIONS + 1);
    localparam int WW = CW + 2;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_EV  = 14'b00000000000100,
        S_ALLOC    = 14'b00000000001000,
        S_SHIFT_RD = 14'b00000000010000,
        S_SHIFT_WR = 14'b00000000100000,
        S_SPLIT_HI = 14'b00000001000000,
        S_SPLIT_LO = 14'b00000010000000,
        S_NEXT_RD  = 14'b00000100000000,
        S_NEXT_EV  = 14'b00001000000000,
        S_MERGE    = 14'b00010000000000,
        S_PACK_RD  = 14'b00100000000000,
        S_PACK_WR  = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

    state_t                state_reg, state_next;
    in_word_t              req_reg, req_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         pick_reg, pick_next;
    logic [ADDR_BITS-1:0]  pstart_reg, pstart_next;
    logic [ADDR_BITS-1:0]  psize_reg, psize_next;
    logic                  prev_busy_reg, prev_busy_next;
    logic [ADDR_BITS-1:0]  prev_start_reg, prev_start_next;
    logic [ADDR_BITS-1:0]  prev_size_reg, prev_size_next;
    logic                  next_busy_reg, next_busy_next;
    logic [ADDR_BITS-1:0]  next_size_reg, next_size_next;
    logic [1:0]            nrm_reg, nrm_next;
    out_word_t             res_reg, res_next;
    out_word_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  fit;
    logic                  first_fit;
    logic                  merge_prev;
    logic [ADDR_BITS-1:0]  merged_size;
    logic [WW-1:0]         pick_w;
    logic [WW-1:0]         idx_w;
    logic [WW-1:0]         count_w;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pstart_next     = pstart_reg;
        psize_next      = psize_reg;
        prev_busy_next  = prev_busy_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        next_busy_next  = next_busy_reg;
        next_size_next  = next_size_reg;
        nrm_next        = nrm_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = pick_reg;
        wr_data = rd_data;

        pick_w     = WW'(pick_reg);
        idx_w      = WW'(idx_reg);
        count_w    = WW'(count_reg);
        fit        = !rd_data.busy && (rd_data.size >= req_reg.request_size);
        first_fit  = (fit_mode != FIT_BEST) && (fit_mode != FIT_WORST);
        merge_prev = (pick_reg != '0) && !prev_busy_reg;
        merged_size = psize_reg + (next_busy_reg ? '0 : next_size_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = in_data;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    prev_busy_next = 1'b1;
                    res_next       = '0;
                    if (in_data.func == FUNC_ALLOC)
                    begin
                        if (in_data.request_size == '0)
                        begin
                            res_next.status = STATUS_NO_FIT;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    else if (JCNT_BITS'(in_data.job_id) >= job_count)
                    begin
                        res_next.status = STATUS_BAD_JOB;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_EV;
                end
                else if (req_reg.func == FUNC_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    res_next.status = STATUS_NO_FIT;
                    state_next      = S_OUT;
                end
            end

            S_SCAN_EV:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN_RD;
                if (req_reg.func == FUNC_ALLOC)
                begin
                    if (fit)
                    begin
                        if (!found_reg
                            || (fit_mode == FIT_BEST && rd_data.size < psize_reg)
                            || (fit_mode == FIT_WORST && rd_data.size > psize_reg))
                        begin
                            found_next  = 1'b1;
                            pick_next   = idx_reg[IW-1:0];
                            pstart_next = rd_data.start;
                            psize_next  = rd_data.size;
                        end
                        if (!found_reg && first_fit)
                        begin
                            state_next = S_ALLOC;
                        end
                    end
                end
                else if (rd_data.busy && rd_data.owner == req_reg.job_id)
                begin
                    pick_next   = idx_reg[IW-1:0];
                    pstart_next = rd_data.start;
                    psize_next  = rd_data.size;
                    state_next  = S_NEXT_RD;
                end
                else
                begin
                    prev_busy_next  = rd_data.busy;
                    prev_start_next = rd_data.start;
                    prev_size_next  = rd_data.size;
                end
            end

            S_ALLOC:
            begin
                if (!found_reg)
                begin
                    res_next.status = STATUS_NO_FIT;
                    state_next      = S_OUT;
                end
                else if (psize_reg == req_reg.request_size)
                begin
                    wr_en                  = 1'b1;
                    wr_data.start          = pstart_reg;
                    wr_data.size           = psize_reg;
                    wr_data.busy           = 1'b1;
                    wr_data.owner          = req_reg.job_id;
                    res_next.status        = STATUS_OK;
                    res_next.start_address = pstart_reg;
                    state_next             = S_OUT;
                end
                else if (count_w >= WW'(MAX_PARTITIONS))
                begin
                    res_next.status = STATUS_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next = count_reg;
                    if (count_w > pick_w + 1'b1)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_SPLIT_HI;
                    end
                end
            end

            // Entries behind the pick move up by one, highest first.
            S_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IW'(idx_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[IW-1:0];
                idx_next = idx_reg - 1'b1;
                if (idx_w - 1'b1 > pick_w + 1'b1)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_SPLIT_HI;
                end
            end

            S_SPLIT_HI:
            begin
                wr_en         = 1'b1;
                wr_addr       = pick_reg + 1'b1;
                wr_data.start = pstart_reg + req_reg.request_size;
                wr_data.size  = psize_reg - req_reg.request_size;
                wr_data.busy  = 1'b0;
                wr_data.owner = '0;
                state_next    = S_SPLIT_LO;
            end

            S_SPLIT_LO:
            begin
                wr_en                  = 1'b1;
                wr_data.start          = pstart_reg;
                wr_data.size           = req_reg.request_size;
                wr_data.busy           = 1'b1;
                wr_data.owner          = req_reg.job_id;
                count_next             = count_reg + 1'b1;
                res_next.status        = STATUS_OK;
                res_next.start_address = pstart_reg;
                state_next             = S_OUT;
            end

            S_NEXT_RD:
            begin
                if (pick_w + 1'b1 < count_w)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pick_reg + 1'b1;
                    state_next = S_NEXT_EV;
                end
                else
                begin
                    next_busy_next = 1'b1;
                    state_next     = S_MERGE;
                end
            end

            S_NEXT_EV:
            begin
                next_busy_next = rd_data.busy;
                next_size_next = rd_data.size;
                state_next     = S_MERGE;
            end

            // Write the merged free entry, then close the gap behind it.
            S_MERGE:
            begin
                wr_en         = 1'b1;
                wr_data.busy  = 1'b0;
                wr_data.owner = req_reg.job_id;
                if (merge_prev)
                begin
                    wr_addr       = pick_reg - 1'b1;
                    wr_data.start = prev_start_reg;
                    wr_data.size  = prev_size_reg + merged_size;
                    idx_next      = CW'(pick_reg);
                end
                else
                begin
                    wr_addr       = pick_reg;
                    wr_data.start = pstart_reg;
                    wr_data.size  = merged_size;
                    idx_next      = CW'(pick_w + 1'b1);
                end
                nrm_next               = 2'(merge_prev) + 2'(!next_busy_reg);
                res_next.status        = STATUS_OK;
                res_next.start_address = pstart_reg;
                state_next             = S_PACK_RD;
            end

            S_PACK_RD:
            begin
                if (idx_w + WW'(nrm_reg) < count_w)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(idx_w + WW'(nrm_reg));
                    state_next = S_PACK_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(nrm_reg);
                    state_next = S_OUT;
                end
            end

            S_PACK_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[IW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_PACK_RD;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (init)
        begin
            count_next = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pstart_reg     <= pstart_next;
        psize_reg      <= psize_next;
        prev_busy_reg  <= prev_busy_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        next_busy_reg  <= next_busy_next;
        next_size_reg  <= next_size_next;
        nrm_reg        <= nrm_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule
`default_nettype wire
